// ===== rtl/core/sbiq_pkg.sv =====
// Shared types and constants for the stereo cascaded biquad core.
// Used by sbiq_ctrl, sbiq_datapath and the top level; depends on nothing.
package sbiq_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 20;
   localparam int CSR_INDEX_WIDTH  = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HP_FEEDFWD = 3'd0,
      CSR_HP_FEEDBACK = 3'd1,
      CSR_LP_FEEDFWD = 3'd2,
      CSR_LP_FEEDBACK = 3'd3,
      CSR_STAGE_ENABLES = 3'd4
   } csr_index_type;

   // Filter taps in the order the shared multiplier visits them.
   typedef enum logic [2:0] {
      TAP_B0 = 3'd0,
      TAP_B1 = 3'd1,
      TAP_B2 = 3'd2,
      TAP_A1 = 3'd3,
      TAP_A2 = 3'd4
   } tap_type;

   typedef struct packed {
      logic    load_input;
      logic    mul_en;
      tap_type tap;
      logic    ch;
      logic    stage;
      logic    round_en;
      logic    out_load;
   } sbiq_cmd_type;

   typedef struct packed {
      logic [1:0] enables;
      logic       out_busy;
   } sbiq_status_type;

endpackage

// ===== rtl/core/stereo_cascaded_biquad_hpf_lpf_core.sv =====
// Top level of the stereo cascaded biquad core (high-pass then low-pass).
// Instantiates sbiq_ctrl and sbiq_datapath; uses sbiq_pkg.
//
// Usage:
// - Request channel: req_left_in / req_right_in with req_valid and req_stall.
//   A request is taken at a clock edge where req_valid is high and req_stall
//   is low. Feed the same sample on both inputs for a mono source.
// - Response channel: rsp_left_out, rsp_right_out and rsp_left_level with
//   rsp_valid and rsp_stall. The response sits in an output register, so the
//   next request is taken while an earlier response still waits.
// - Configuration: csr_write_enable, csr_index, csr_write_data. Write only
//   while the core is idle. Indexes above the register list are ignored.
// - Each enabled biquad pass (one stage on one channel) uses the single shared
//   multiplier: five taps, one accumulate drain and one round-and-saturate
//   step. There are two passes per enabled stage. A request holds the core
//   until its result is loaded into the response register.
// - Reset (synchronous, active high) clears the filter history, restores the
//   default coefficients (unity gain, both stages bypassed) and empties the
//   response register.
// - While rsp_stall is high the response holds, and a finished result waits
//   in the core until the response register frees up; req_stall stays high.
module stereo_cascaded_biquad_hpf_lpf_core #(
   parameter int SAMPLE_WIDTH = sbiq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = sbiq_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_left_in,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_right_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_right_out,
   output logic        [SAMPLE_WIDTH-2:0]       rsp_left_level,
   input  logic                                 csr_write_enable,
   input  logic [sbiq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [3*COEF_WIDTH-1:0]              csr_write_data
);

   // Command and status between the sequencer and the arithmetic.
   sbiq_pkg::sbiq_cmd_type    cmd;
   sbiq_pkg::sbiq_status_type status;

   sbiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sbiq_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_left_level   (rsp_left_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// ===== rtl/core/sbiq_ctrl.sv =====
// Sequencer for the stereo cascaded biquad core.
// Uses sbiq_pkg; drives the datapath only through the command struct.
module sbiq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sbiq_pkg::sbiq_status_type status,
   output sbiq_pkg::sbiq_cmd_type   cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_NEXT   = 6'b000010,
      ST_MAC    = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_ROUND  = 6'b010000,
      ST_OUTPUT = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        pass_ff, pass_in;   // bit1 = channel, bit0 = stage
   sbiq_pkg::tap_type tap_ff, tap_in;
   logic              accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_NEXT;
               pass_in  = 2'd0;
            end
         end
         ST_NEXT: begin
            if (status.enables[pass_ff[0]]) begin
               state_in = ST_MAC;
               tap_in   = sbiq_pkg::TAP_B0;
            end else if (pass_ff == 2'd3) begin
               state_in = ST_OUTPUT;
            end else begin
               pass_in = pass_ff + 2'd1;
            end
         end
         ST_MAC: begin
            if (tap_ff == sbiq_pkg::TAP_A2) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = sbiq_pkg::tap_type'(tap_ff + 3'd1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (pass_ff == 2'd3) begin
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_NEXT;
               pass_in  = pass_ff + 2'd1;
            end
         end
         ST_OUTPUT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load_input = accept;
      cmd.mul_en     = (state_ff == ST_MAC);
      cmd.tap        = tap_ff;
      cmd.ch         = pass_ff[1];
      cmd.stage      = pass_ff[0];
      cmd.round_en   = (state_ff == ST_ROUND);
      cmd.out_load   = (state_ff == ST_OUTPUT) && !status.out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 2'd0;
         tap_ff   <= sbiq_pkg::TAP_B0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         tap_ff   <= tap_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_NEXT)
      else $error("accepted request did not start the pass walk");

   a_last_tap_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && tap_ff == sbiq_pkg::TAP_A2) |=> state_ff == ST_DRAIN)
      else $error("last tap did not move to the drain cycle");

   a_round_after_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> $past(state_ff) == ST_DRAIN)
      else $error("rounding started before the accumulator drained");

endmodule

// ===== rtl/core/sbiq_datapath.sv =====
// Datapath of the stereo cascaded biquad core: registers, history, one shared
// multiplier, accumulator, rounding and saturation. Uses sbiq_pkg.
module sbiq_datapath #(
   parameter int SAMPLE_WIDTH = sbiq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = sbiq_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbiq_pkg::sbiq_cmd_type               cmd,
   output sbiq_pkg::sbiq_status_type            status,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_left_in,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_right_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_right_out,
   output logic        [SAMPLE_WIDTH-2:0]       rsp_left_level,
   input  logic                                 csr_write_enable,
   input  logic [sbiq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [3*COEF_WIDTH-1:0]              csr_write_data
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SUM_W  = ACC_W + 1;
   localparam int FRAC   = COEF_WIDTH - 2;

   localparam logic [3*COEF_WIDTH-1:0] FEEDFWD_RESET =
      {{(2*COEF_WIDTH+1){1'b0}}, 1'b1, {(FRAC){1'b0}}};
   localparam logic signed [SUM_W-1:0] HALF_LSB =
      {{(SUM_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // Configuration registers, indexed by stage (0 = high-pass, 1 = low-pass).
   logic [3*COEF_WIDTH-1:0] feedfwd_ff [2];
   logic [2*COEF_WIDTH-1:0] feedback_ff [2];
   logic [1:0]              enables_ff;

   // Working samples, indexed by channel, and filter history, indexed [stage][channel][age].
   logic signed [SAMPLE_WIDTH-1:0] cur_ff [2];
   logic signed [SAMPLE_WIDTH-1:0] xh_ff [2][2][2];
   logic signed [SAMPLE_WIDTH-1:0] yh_ff [2][2][2];

   logic signed [SAMPLE_WIDTH-1:0] mul_a;
   logic signed [COEF_WIDTH-1:0]   mul_b;
   logic                           mul_sub;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic                           prod_valid_ff;
   logic                           prod_first_ff;
   logic                           prod_sub_ff;
   logic signed [ACC_W-1:0]        prod_ext;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [SUM_W-1:0]        rounded;
   logic signed [SUM_W-1:0]        shifted;
   logic signed [SAMPLE_WIDTH-1:0] stage_out;

   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] left_out_ff, right_out_ff;
   logic        [SAMPLE_WIDTH-2:0] level_ff, level_in;
   logic signed [SAMPLE_WIDTH-1:0] left_neg;

   assign status.enables  = enables_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // Tap selection for the shared multiplier; feedback taps subtract.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_sub = 1'b0;
      unique case (cmd.tap)
         sbiq_pkg::TAP_B0: begin
            mul_a = cur_ff[cmd.ch];
            mul_b = feedfwd_ff[cmd.stage][COEF_WIDTH-1:0];
         end
         sbiq_pkg::TAP_B1: begin
            mul_a = xh_ff[cmd.stage][cmd.ch][0];
            mul_b = feedfwd_ff[cmd.stage][2*COEF_WIDTH-1:COEF_WIDTH];
         end
         sbiq_pkg::TAP_B2: begin
            mul_a = xh_ff[cmd.stage][cmd.ch][1];
            mul_b = feedfwd_ff[cmd.stage][3*COEF_WIDTH-1:2*COEF_WIDTH];
         end
         sbiq_pkg::TAP_A1: begin
            mul_a   = yh_ff[cmd.stage][cmd.ch][0];
            mul_b   = feedback_ff[cmd.stage][COEF_WIDTH-1:0];
            mul_sub = 1'b1;
         end
         sbiq_pkg::TAP_A2: begin
            mul_a   = yh_ff[cmd.stage][cmd.ch][1];
            mul_b   = feedback_ff[cmd.stage][2*COEF_WIDTH-1:COEF_WIDTH];
            mul_sub = 1'b1;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {{2{prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      if (prod_first_ff) begin
         acc_in = prod_sub_ff ? -prod_ext : prod_ext;
      end else begin
         acc_in = prod_sub_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
      end
   end

   // Round half up, floor shift, then clamp to the sample range.
   assign rounded = {acc_ff[ACC_W-1], acc_ff} + HALF_LSB;
   assign shifted = rounded >>> FRAC;

   always_comb begin
      if (shifted > SAT_HI) begin
         stage_out = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         stage_out = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         stage_out = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   // Left level: magnitude, with the most negative sample clamped.
   assign left_neg = -cur_ff[0];
   always_comb begin
      if (!cur_ff[0][SAMPLE_WIDTH-1]) begin
         level_in = cur_ff[0][SAMPLE_WIDTH-2:0];
      end else if (cur_ff[0] == SAMPLE_MIN) begin
         level_in = '1;
      end else begin
         level_in = left_neg[SAMPLE_WIDTH-2:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.mul_en;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration and history: reset restores the default configuration and clears the history.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            feedfwd_ff[s]  <= FEEDFWD_RESET;
            feedback_ff[s] <= '0;
            for (int c = 0; c < 2; c++) begin
               for (int k = 0; k < 2; k++) begin
                  xh_ff[s][c][k] <= '0;
                  yh_ff[s][c][k] <= '0;
               end
            end
         end
         enables_ff <= 2'b00;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               sbiq_pkg::CSR_HP_FEEDFWD:    feedfwd_ff[0]  <= csr_write_data;
               sbiq_pkg::CSR_HP_FEEDBACK:   feedback_ff[0] <=
                                               csr_write_data[2*COEF_WIDTH-1:0];
               sbiq_pkg::CSR_LP_FEEDFWD:    feedfwd_ff[1]  <= csr_write_data;
               sbiq_pkg::CSR_LP_FEEDBACK:   feedback_ff[1] <=
                                               csr_write_data[2*COEF_WIDTH-1:0];
               sbiq_pkg::CSR_STAGE_ENABLES: enables_ff     <= csr_write_data[1:0];
               default: begin
               end
            endcase
         end
         if (cmd.round_en) begin
            xh_ff[cmd.stage][cmd.ch][1] <= xh_ff[cmd.stage][cmd.ch][0];
            xh_ff[cmd.stage][cmd.ch][0] <= cur_ff[cmd.ch];
            yh_ff[cmd.stage][cmd.ch][1] <= yh_ff[cmd.stage][cmd.ch][0];
            yh_ff[cmd.stage][cmd.ch][0] <= stage_out;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.mul_en) begin
         prod_first_ff <= (cmd.tap == sbiq_pkg::TAP_B0);
         prod_sub_ff   <= mul_sub;
      end
      if (prod_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.load_input) begin
         cur_ff[0] <= req_left_in;
         cur_ff[1] <= req_right_in;
      end else if (cmd.round_en) begin
         cur_ff[cmd.ch] <= stage_out;
      end
      if (cmd.out_load) begin
         left_out_ff  <= cur_ff[0];
         right_out_ff <= cur_ff[1];
         level_ff     <= level_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_out   = left_out_ff;
   assign rsp_right_out  = right_out_ff;
   assign rsp_left_level = level_ff;

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result did not appear on the response channel");

   a_round_after_settle: assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> !prod_valid_ff)
      else $error("rounding while a product is still being accumulated");

   a_stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_left_out)
         && $stable(rsp_right_out) && $stable(rsp_left_level)))
      else $error("stalled response changed or was dropped");

endmodule

// ===== tb/sbiq_response_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the stereo cascaded biquad core: tracks register writes,
// predicts each response from the accepted requests and compares it. Uses sbiq_pkg.
module sbiq_response_checker (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_stall,
   input  logic signed [sbiq_pkg::SAMPLE_WIDTH_DEF-1:0] req_left_in,
   input  logic signed [sbiq_pkg::SAMPLE_WIDTH_DEF-1:0] req_right_in,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   input  logic signed [sbiq_pkg::SAMPLE_WIDTH_DEF-1:0] rsp_left_out,
   input  logic signed [sbiq_pkg::SAMPLE_WIDTH_DEF-1:0] rsp_right_out,
   input  logic        [sbiq_pkg::SAMPLE_WIDTH_DEF-2:0] rsp_left_level,
   input  logic                                         csr_write_enable,
   input  logic        [sbiq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic        [3*sbiq_pkg::COEF_WIDTH_DEF-1:0] csr_write_data,
   output int                                           mismatch_count,
   output int                                           outstanding_count
);

   localparam int SW = sbiq_pkg::SAMPLE_WIDTH_DEF;
   localparam int CW = sbiq_pkg::COEF_WIDTH_DEF;
   localparam int FRAC_BITS = CW - 2;
   localparam int HIGHPASS = 0;
   localparam int LOWPASS = 1;
   localparam longint SAMPLE_HI = (longint'(1) << (SW - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
   localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);
   localparam logic [3*CW-1:0] FEEDFWD_ONE = {{(2*CW+1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic signed [SW-1:0] left_out;
      logic signed [SW-1:0] right_out;
      logic        [SW-2:0] left_level;
   } filtered_pair_type;

   logic [3*CW-1:0] hp_feedfwd, lp_feedfwd;
   logic [2*CW-1:0] hp_feedback, lp_feedback;
   logic [1:0]      stage_enables;

   // Index [stage][2*channel + age], age 0 the previous sample.
   logic signed [SW-1:0] x_hist [2][4];
   logic signed [SW-1:0] y_hist [2][4];

   filtered_pair_type expected_responses [$];

   function automatic longint coef_of(input logic [3*CW-1:0] word, input int k);
      logic signed [CW-1:0] c;
      c = word[k*CW +: CW];
      return longint'(c);
   endfunction

   // One direct form I pass of one stage on one channel, with history update.
   function automatic logic signed [SW-1:0] run_biquad(input int stage, input int ch,
                                                        input logic signed [SW-1:0] x);
      logic [3*CW-1:0] ff;
      logic [3*CW-1:0] fb;
      longint acc;
      int i;
      i = 2 * ch;
      ff = (stage == HIGHPASS) ? hp_feedfwd : lp_feedfwd;
      fb = {{CW{1'b0}}, ((stage == HIGHPASS) ? hp_feedback : lp_feedback)};
      acc = coef_of(ff, 0) * x + coef_of(ff, 1) * x_hist[stage][i]
          + coef_of(ff, 2) * x_hist[stage][i+1]
          - coef_of(fb, 0) * y_hist[stage][i] - coef_of(fb, 1) * y_hist[stage][i+1];
      acc = (acc + ROUND_HALF) >>> FRAC_BITS;
      if (acc > SAMPLE_HI) acc = SAMPLE_HI;
      else if (acc < SAMPLE_LO) acc = SAMPLE_LO;
      x_hist[stage][i+1] = x_hist[stage][i];
      x_hist[stage][i] = x;
      y_hist[stage][i+1] = y_hist[stage][i];
      y_hist[stage][i] = acc[SW-1:0];
      return acc[SW-1:0];
   endfunction

   function automatic filtered_pair_type filter_sample_pair(
                                                input logic signed [SW-1:0] left,
                                                input logic signed [SW-1:0] right);
      logic signed [SW-1:0] s [2];
      filtered_pair_type res;
      longint mag;
      s[0] = left;
      s[1] = right;
      for (int ch = 0; ch < 2; ch++) begin
         if (stage_enables[0]) s[ch] = run_biquad(HIGHPASS, ch, s[ch]);
         if (stage_enables[1]) s[ch] = run_biquad(LOWPASS, ch, s[ch]);
      end
      mag = longint'(s[0]);
      if (mag < 0) mag = -mag;
      if (mag > SAMPLE_HI) mag = SAMPLE_HI;
      res.left_out = s[0];
      res.right_out = s[1];
      res.left_level = mag[SW-2:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < 50)
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      filtered_pair_type want;
      if (reset) begin
         hp_feedfwd = FEEDFWD_ONE;
         lp_feedfwd = FEEDFWD_ONE;
         hp_feedback = '0;
         lp_feedback = '0;
         stage_enables = '0;
         for (int st = 0; st < 2; st++) begin
            for (int e = 0; e < 4; e++) begin
               x_hist[st][e] = '0;
               y_hist[st][e] = '0;
            end
         end
         expected_responses.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               sbiq_pkg::CSR_HP_FEEDFWD:    hp_feedfwd = csr_write_data;
               sbiq_pkg::CSR_HP_FEEDBACK:   hp_feedback = csr_write_data[2*CW-1:0];
               sbiq_pkg::CSR_LP_FEEDFWD:    lp_feedfwd = csr_write_data;
               sbiq_pkg::CSR_LP_FEEDBACK:   lp_feedback = csr_write_data[2*CW-1:0];
               sbiq_pkg::CSR_STAGE_ENABLES: stage_enables = csr_write_data[1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_responses.push_back(filter_sample_pair(req_left_in, req_right_in));
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no request outstanding",
                               longint'(rsp_left_out), longint'(0));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_left_out !== want.left_out)
                  report_mismatch("left_out", longint'(rsp_left_out),
                                  longint'(want.left_out));
               if (rsp_right_out !== want.right_out)
                  report_mismatch("right_out", longint'(rsp_right_out),
                                  longint'(want.right_out));
               if (rsp_left_level !== want.left_level)
                  report_mismatch("left_level", longint'(rsp_left_level),
                                  longint'(want.left_level));
            end
         end
      end
      outstanding_count = expected_responses.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the stereo cascaded biquad core: clock, reset, requests,
// response back-pressure and the verdict. Uses sbiq_pkg and sbiq_response_checker.
module tb_top;

   localparam int SW = sbiq_pkg::SAMPLE_WIDTH_DEF;
   localparam int CW = sbiq_pkg::COEF_WIDTH_DEF;
   localparam int CIW = sbiq_pkg::CSR_INDEX_WIDTH;
   localparam int COEF_ONE = 1 << (CW - 2);
   localparam int COEF_MAX = (1 << (CW - 1)) - 1;
   localparam int COEF_MIN = -(1 << (CW - 1));
   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic [1:0] ENABLE_NONE = 2'd0;
   localparam logic [1:0] ENABLE_HIGHPASS = 2'd1;
   localparam logic [1:0] ENABLE_LOWPASS = 2'd2;
   localparam logic [1:0] ENABLE_BOTH = 2'd3;
   localparam int RANDOM_REQUESTS = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [SW-1:0] req_left_in = '0;
   logic signed [SW-1:0] req_right_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [SW-1:0] rsp_left_out;
   logic signed [SW-1:0] rsp_right_out;
   logic        [SW-2:0] rsp_left_level;
   logic                 csr_write_enable = 1'b0;
   logic [CIW-1:0]       csr_index = '0;
   logic [3*CW-1:0]      csr_write_data = '0;

   int mismatch_count;
   int pending_responses;

   // When set, both sides stop idling so that back-to-back traffic is seen too.
   bit burst_mode = 1'b0;
   // Set by the stimulus to ask the response side for one long hold-off.
   bit hold_off_request = 1'b0;

   stereo_cascaded_biquad_hpf_lpf_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_left_level   (rsp_left_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   sbiq_response_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_left_in       (req_left_in),
      .req_right_in      (req_right_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_out      (rsp_left_out),
      .rsp_right_out     (rsp_right_out),
      .rsp_left_level    (rsp_left_level),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (pending_responses)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Samples lean on the rails and on small values, where rounding and
   // saturation are most likely to go wrong; the rest are full-range random.
   function automatic logic signed [SW-1:0] random_sample();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SW'(int'($urandom_range(0, 2000)) - 1000);
         default: return w[SW-1:0];
      endcase
   endfunction

   function automatic logic [CW-1:0] tame_coef(input int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      return v[CW-1:0];
   endfunction

   function automatic logic [3*CW-1:0] pack_feedfwd(input int b0, input int b1, input int b2);
      logic [CW-1:0] c0, c1, c2;
      c0 = b0[CW-1:0];
      c1 = b1[CW-1:0];
      c2 = b2[CW-1:0];
      return {c2, c1, c0};
   endfunction

   function automatic logic [3*CW-1:0] pack_feedback(input int a1, input int a2);
      logic [CW-1:0] c1, c2;
      c1 = a1[CW-1:0];
      c2 = a2[CW-1:0];
      return {{CW{1'b0}}, c2, c1};
   endfunction

   // Now and then any bit pattern at all; otherwise gains within plus or minus one.
   function automatic logic [3*CW-1:0] random_feedfwd();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) return w[3*CW-1:0];
      return {tame_coef(COEF_ONE), tame_coef(COEF_ONE), tame_coef(COEF_ONE)};
   endfunction

   // Poles stay inside the unit circle for |a1| <= 0.5 and |a2| <= 0.25. The
   // bits above the register are random as well, since the core must drop them.
   function automatic logic [3*CW-1:0] random_feedback();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) return w[3*CW-1:0];
      return {w[3*CW-1:2*CW], tame_coef(COEF_ONE / 4), tame_coef(COEF_ONE / 2)};
   endfunction

   // Offers one request after a random idle gap and returns at the clock edge
   // where the core takes it. The payload holds still while the core stalls.
   task automatic put_request(input logic signed [SW-1:0] left,
                              input logic signed [SW-1:0] right);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_in <= left;
      req_right_in <= right;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering and waits until every predicted response has come back,
   // then lets the core settle before any register is touched.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CIW-1:0] index,
                                 input logic [3*CW-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Response side: random stalls of random length, plus one long hold-off on
   // request so that the core fills up and has to stall its input.
   initial begin : response_sink
      int n;
      forever begin
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat (1 + pick_gap()) @(posedge clock);
      end
   end

   initial begin : stimulus
      int sent;
      int phase;
      int length;
      logic [63:0] w;
      logic signed [SW-1:0] left;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset both stages are bypassed, so every sample must come back
      // unchanged. A left sample at the negative rail has a magnitude one past
      // the largest level and must clip.
      put_request(SAMPLE_MAX, SAMPLE_MIN);
      put_request(SAMPLE_MIN, SAMPLE_MAX);
      put_request('0, '0);
      put_request(SW'(-1), SW'(1));
      put_request(SAMPLE_MIN, SAMPLE_MIN);
      drain_results();

      // A realistic high-pass and low-pass pair, first with only the high-pass on.
      write_register(sbiq_pkg::CSR_HP_FEEDFWD, pack_feedfwd(235930, -471860, 235930));
      write_register(sbiq_pkg::CSR_HP_FEEDBACK, pack_feedback(-419430, 167772));
      write_register(sbiq_pkg::CSR_LP_FEEDFWD, pack_feedfwd(15729, 31457, 15729));
      write_register(sbiq_pkg::CSR_LP_FEEDBACK, pack_feedback(-314573, 117965));
      write_register(sbiq_pkg::CSR_STAGE_ENABLES, (3*CW)'(ENABLE_HIGHPASS));
      put_request(SAMPLE_MAX, SAMPLE_MAX);
      put_request(SAMPLE_MAX, SAMPLE_MAX);
      put_request('0, SAMPLE_MIN);
      put_request(SW'(12345), SW'(12345));
      drain_results();

      write_register(sbiq_pkg::CSR_STAGE_ENABLES, (3*CW)'(ENABLE_BOTH));
      put_request(SAMPLE_MIN, SAMPLE_MAX);
      put_request(SAMPLE_MAX, SAMPLE_MIN);
      put_request('0, '0);
      drain_results();

      // Switching the high-pass off must freeze its history; switching it back
      // on must pick the frozen values up again.
      write_register(sbiq_pkg::CSR_STAGE_ENABLES, (3*CW)'(ENABLE_LOWPASS));
      put_request(SAMPLE_MAX, SAMPLE_MAX);
      put_request(SW'(-1), SW'(-1));
      drain_results();
      write_register(sbiq_pkg::CSR_STAGE_ENABLES, (3*CW)'(ENABLE_BOTH));
      put_request('0, '0);
      drain_results();

      // Coefficient extremes: all ones (every tap minus one LSB, with the bits
      // above the feedback register set) on the high-pass, then the largest
      // low-pass feedforward gains against the most negative feedback, which
      // saturate it. Writes to indexes past the register list must be dropped.
      write_register(sbiq_pkg::CSR_HP_FEEDFWD, '1);
      write_register(sbiq_pkg::CSR_HP_FEEDBACK, '1);
      write_register(sbiq_pkg::CSR_LP_FEEDFWD, pack_feedfwd(COEF_MAX, COEF_MAX, COEF_MAX));
      write_register(sbiq_pkg::CSR_LP_FEEDBACK, pack_feedback(COEF_MIN, COEF_MIN));
      for (int k = int'(sbiq_pkg::CSR_STAGE_ENABLES) + 1; k < (1 << CIW); k++)
         write_register(CIW'(k), '1);
      write_register(sbiq_pkg::CSR_STAGE_ENABLES, '1);
      put_request(SAMPLE_MAX, SAMPLE_MIN);
      put_request(SAMPLE_MIN, SAMPLE_MAX);
      put_request(SAMPLE_MAX, SAMPLE_MAX);
      put_request('0, '0);
      drain_results();

      // All-zero feedforward on the low-pass leaves only its feedback driving the output.
      write_register(sbiq_pkg::CSR_LP_FEEDFWD, '0);
      write_register(sbiq_pkg::CSR_STAGE_ENABLES, (3*CW)'(ENABLE_LOWPASS));
      put_request(SAMPLE_MAX, SAMPLE_MIN);

      // Random part: phases of random coefficients and enables, each written
      // while the core is idle, followed by a run of random requests. Mono
      // requests carry the same sample on both channels.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         drain_results();
         burst_mode = 1'b0;
         write_register(sbiq_pkg::CSR_HP_FEEDFWD, random_feedfwd());
         write_register(sbiq_pkg::CSR_HP_FEEDBACK, random_feedback());
         write_register(sbiq_pkg::CSR_LP_FEEDFWD, random_feedfwd());
         write_register(sbiq_pkg::CSR_LP_FEEDBACK, random_feedback());
         w = {$urandom, $urandom};
         w[1:0] = (phase == 0) ? ENABLE_BOTH : 2'($urandom_range(ENABLE_NONE, ENABLE_BOTH));
         write_register(sbiq_pkg::CSR_STAGE_ENABLES, w[3*CW-1:0]);
         burst_mode = (phase > 1) && ($urandom_range(0, 3) == 0);
         length = $urandom_range(20, 60);
         for (int k = 0; k < length; k++) begin
            // First phase: the response side holds off for a long time while
            // requests keep coming, so the core backs up into its input.
            if (phase == 0 && k == 5) hold_off_request = 1'b1;
            // Second phase: a pause in the middle until the core has answered
            // everything, then the stream resumes on the same history.
            if (phase == 1 && k == length / 2) drain_results();
            left = random_sample();
            put_request(left, ($urandom_range(0, 3) == 0) ? left : random_sample());
            sent++;
         end
         phase++;
      end

      burst_mode = 1'b0;
      drain_results();
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Far beyond the slowest correct run; a response that never comes ends here.
   initial begin : watchdog
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
